[rtl/core/mean_variance_two_pass_defines.svh]
// ----------------------------------------------------------------------------
// mean_variance_two_pass_defines
// assertion macros shared by the mean and variance block
// ----------------------------------------------------------------------------
`ifndef MEAN_VARIANCE_TWO_PASS_DEFINES_SVH
`define MEAN_VARIANCE_TWO_PASS_DEFINES_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define MVTP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvtp same-cycle check failed");

// antecedent implies consequent in the next cycle
`define MVTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mvtp next-cycle check failed");

`else

`define MVTP_ASSERT_SAME(lbl, ante, cons)
`define MVTP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/core/mvtp_pkg.sv]
// ----------------------------------------------------------------------------
// mvtp_pkg
// constants and controller/datapath interface types for mean and variance
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvtp_pkg;

    localparam int DEPTH       = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;

    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = ADDR_BITS + 1;
    localparam int SUM_BITS  = SAMPLE_BITS + ADDR_BITS + 1;
    localparam int MAG_BITS  = SAMPLE_BITS + FRAC_BITS;
    localparam int DEV_BITS  = MAG_BITS + 1;
    localparam int PROD_BITS = 2 * MAG_BITS;
    localparam int SQ_BITS   = PROD_BITS - FRAC_BITS;
    localparam int ACC_BITS  = SQ_BITS + CNT_BITS + 1;
    localparam int STEP_BITS = $clog2(ACC_BITS + 1);

    // fixed result field widths
    localparam int MEAN_BITS = 32;
    localparam int VAR_BITS  = 46;

    // divider operand select
    localparam logic SEL_MEAN = 1'b0;
    localparam logic SEL_VAR  = 1'b1;

    typedef struct packed {
        logic take;
        logic div_start;
        logic div_sel;
        logic mean_load;
        logic rd_issue;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic rd_last;
        logic pipe_empty;
        logic out_free;
    } stat_t;

endpackage

[rtl/core/mvtp_div.sv]
// ----------------------------------------------------------------------------
// mvtp_div
// restoring divider, one quotient bit per cycle, divides by the sample count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvtp_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mvtp_pkg::ACC_BITS-1:0] dividend,
    input  logic [mvtp_pkg::CNT_BITS-1:0] divisor,
    output logic [mvtp_pkg::ACC_BITS-1:0] quotient,
    output logic                          done
);
    import mvtp_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [ACC_BITS-1:0]  dq_reg, dq_next;
    logic [CNT_BITS-1:0]  rem_reg, rem_next;
    logic [CNT_BITS-1:0]  dsr_reg, dsr_next;
    logic [CNT_BITS:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, dq_reg[ACC_BITS-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_BITS'(ACC_BITS);
            dq_next   = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = CNT_BITS'(trial - {1'b0, dsr_reg});
                dq_next  = {dq_reg[ACC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = CNT_BITS'(trial);
                dq_next  = {dq_reg[ACC_BITS-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    // quotient holds until the next start
    assign quotient = dq_reg;
    assign done     = done_reg;

endmodule

[rtl/core/mvtp_dp.sv]
// ----------------------------------------------------------------------------
// mvtp_dp
// sample store, running sum, deviation-square pipeline and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvtp_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [mvtp_pkg::SAMPLE_BITS-1:0] sample,
    input  mvtp_pkg::cmd_t                       cmd,
    output mvtp_pkg::stat_t                      stat,
    input  logic                                 result_stall,
    output logic                                 result_valid,
    output logic signed [mvtp_pkg::MEAN_BITS-1:0] mean,
    output logic [mvtp_pkg::VAR_BITS-1:0]        variance,
    output logic [mvtp_pkg::CNT_BITS-1:0]        sample_count,
    output logic                                 overflow
);
    import mvtp_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

    logic [CNT_BITS-1:0]         count_reg, count_next;
    logic signed [SUM_BITS-1:0]  sum_reg, sum_next;
    logic                        drop_reg, drop_next;
    logic                        full;

    logic [ADDR_BITS-1:0]        rd_addr_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [MAG_BITS-1:0]  mean_reg;
    logic signed [DEV_BITS-1:0]  dev_reg;
    logic [MAG_BITS-1:0]         mag_reg;
    logic [SQ_BITS-1:0]          sq_reg;
    logic [ACC_BITS-1:0]         acc_reg;
    logic [3:0]                  pv_reg;

    logic signed [DEV_BITS-1:0]  dev_next;
    logic [PROD_BITS-1:0]        prod;
    logic [SUM_BITS-1:0]         abs_sum;
    logic [ACC_BITS-1:0]         div_dividend;
    logic [ACC_BITS-1:0]         quot;
    logic [ACC_BITS-1:0]         mean_signed;
    logic                        div_done;

    logic                        res_valid_reg, res_valid_next;
    logic signed [MEAN_BITS-1:0] res_mean_reg;
    logic [VAR_BITS-1:0]         res_var_reg;
    logic [CNT_BITS-1:0]         res_count_reg;
    logic                        res_ovf_reg;

    assign full = (count_reg == CNT_BITS'(DEPTH));

    // collect phase: store, count and sum; cleared once the result is taken over
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        drop_next  = drop_reg;
        if (cmd.result_load)
        begin
            count_next = '0;
            sum_next   = '0;
            drop_next  = 1'b0;
        end
        else if (cmd.take)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SUM_BITS'(sample);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && !full)
        begin
            mem[count_reg[ADDR_BITS-1:0]] <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    // shared divider: |sum| << frac for the mean, square total for the variance
    assign abs_sum      = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
    assign div_dividend = (cmd.div_sel == SEL_MEAN) ?
                          (ACC_BITS'(abs_sum) << FRAC_BITS) : acc_reg;

    mvtp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .quotient (quot),
        .done     (div_done)
    );

    assign mean_signed = sum_reg[SUM_BITS-1] ? (~quot + 1'b1) : quot;

    always_ff @(posedge clk)
    begin
        if (cmd.mean_load)
        begin
            mean_reg <= MAG_BITS'(mean_signed);
        end
    end

    // second pass pipeline: read, deviation, magnitude, square, accumulate
    assign dev_next = (DEV_BITS'(rd_data_reg) <<< FRAC_BITS) - DEV_BITS'(mean_reg);
    assign prod     = PROD_BITS'(mag_reg) * PROD_BITS'(mag_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg <= '0;
            pv_reg      <= '0;
        end
        else
        begin
            pv_reg <= {pv_reg[2:0], cmd.rd_issue};
            if (cmd.mean_load)
            begin
                rd_addr_reg <= '0;
            end
            else if (cmd.rd_issue)
            begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dev_reg <= dev_next;
        mag_reg <= dev_reg[DEV_BITS-1] ? MAG_BITS'(-dev_reg) : MAG_BITS'(dev_reg);
        sq_reg  <= prod[PROD_BITS-1:FRAC_BITS];
        if (cmd.mean_load)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg[3])
        begin
            acc_reg <= acc_reg + ACC_BITS'(sq_reg);
        end
    end

    // result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.result_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            res_mean_reg  <= MEAN_BITS'(mean_reg);
            res_var_reg   <= VAR_BITS'(quot);
            res_count_reg <= count_reg;
            res_ovf_reg   <= drop_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign mean         = res_mean_reg;
    assign variance     = res_var_reg;
    assign sample_count = res_count_reg;
    assign overflow     = res_ovf_reg;

    assign stat.div_done   = div_done;
    assign stat.rd_last    = ({1'b0, rd_addr_reg} + 1'b1) == count_reg;
    assign stat.pipe_empty = (pv_reg == '0);
    assign stat.out_free   = !res_valid_reg || !result_stall;

endmodule

[rtl/core/mvtp_ctrl.sv]
// ----------------------------------------------------------------------------
// mvtp_ctrl
// sequencer: collect, mean division, second pass, variance division, output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvtp_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    input  logic            last,
    output logic            sample_stall,
    output mvtp_pkg::cmd_t  cmd,
    input  mvtp_pkg::stat_t stat
);
    import mvtp_pkg::*;

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_MSTART  = 3'd1;
    localparam logic [2:0] S_MWAIT   = 3'd2;
    localparam logic [2:0] S_PASS    = 3'd3;
    localparam logic [2:0] S_DRAIN   = 3'd4;
    localparam logic [2:0] S_VSTART  = 3'd5;
    localparam logic [2:0] S_VWAIT   = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.div_sel     = SEL_MEAN;
        unique case (state_reg)
            S_COLLECT:
            begin
                if (sample_valid)
                begin
                    cmd.take = 1'b1;
                    if (last)
                    begin
                        state_next = S_MSTART;
                    end
                end
            end
            S_MSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_load = 1'b1;
                    state_next    = S_PASS;
                end
            end
            S_PASS:
            begin
                cmd.rd_issue = 1'b1;
                if (stat.rd_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    state_next = S_VSTART;
                end
            end
            S_VSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_VAR;
                state_next    = S_VWAIT;
            end
            S_VWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // wait until the previous result has been transferred
                if (stat.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign sample_stall = (state_reg != S_COLLECT);

endmodule

[rtl/core/mean_variance_two_pass.sv]
// ----------------------------------------------------------------------------
// mean_variance_two_pass
// two-pass mean and population variance over a stored set of samples
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  -------   --------------------------   ----------------------------------
//  samples   sample_valid / sample_stall  sample, last
//  result    result_valid / result_stall  mean, variance, sample_count,
//                                         overflow
//
//  samples transfer at one per cycle until the one marked last
//  then, for n stored samples, two 62-step divisions
//  in the shared bit-serial divider plus one store read per sample
//  the next set may start while the previous result still waits on result_stall
//  reset clears control and sums only; no pass over the sample store is needed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mean_variance_two_pass_defines.svh"

module mean_variance_two_pass
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [mvtp_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                    last,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [mvtp_pkg::MEAN_BITS-1:0]   mean,
    output logic [mvtp_pkg::VAR_BITS-1:0]           variance,
    output logic [mvtp_pkg::CNT_BITS-1:0]           sample_count,
    output logic                                    overflow
);
    import mvtp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mvtp_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .last         (last),
        .sample_stall (sample_stall),
        .cmd          (cmd),
        .stat         (stat)
    );

    mvtp_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cmd          (cmd),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .mean         (mean),
        .variance     (variance),
        .sample_count (sample_count),
        .overflow     (overflow)
    );

    `MVTP_ASSERT_SAME(a_no_overwrite, cmd.result_load, stat.out_free)
    `MVTP_ASSERT_NEXT(a_load_shows, cmd.result_load, result_valid)
    `MVTP_ASSERT_SAME(a_ovf_full, result_valid && overflow, sample_count == CNT_BITS'(DEPTH))
    `MVTP_ASSERT_SAME(a_count_nonzero, result_valid, sample_count != '0)

endmodule
